// File: rtl/grid_ray_caster_unit_assert.svh
// ----------------------------------------------------------------------------
// grid_ray_caster_unit_assert.svh
// Assertion macros used by the grid ray caster checker.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_UNIT_ASSERT_SVH
`define GRID_RAY_CASTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Types, constants and helper functions of the grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

    // Map geometry
    localparam int MAP_WIDTH  = 8;
    localparam int MAP_HEIGHT = 8;
    localparam int MAP_CELLS  = MAP_WIDTH * MAP_HEIGHT;
    localparam int CELL_SHIFT = 6;
    localparam int POS_SHIFT  = CELL_SHIFT + 8;
    localparam int COL_W      = $clog2(MAP_WIDTH);
    localparam int ROW_W      = $clog2(MAP_HEIGHT);
    localparam int IDX_W      = $clog2(MAP_CELLS);

    // Angle and trigonometry
    localparam int ANGLE_W     = 12;
    localparam int TURN_W      = 16;
    localparam int TRIG_FRAC   = 14;
    localparam int TRIG_W      = TRIG_FRAC + 1;
    localparam int TRIG_ONE    = 1 << TRIG_FRAC;
    localparam int CORDIC_ITERS = 14;
    localparam int CORDIC_X0   = 9949;
    localparam int CX_W        = 18;
    localparam int CZ_W        = 16;
    localparam int ITER_W      = 4;

    // Datapath widths
    localparam int POS_W   = 17;
    localparam int STEP_W  = 4;
    localparam int LINE_W  = 21;
    localparam int PT_W    = 25;
    localparam int D_W     = POS_SHIFT + 5;
    localparam int OFF_W   = 34;
    localparam int OFF_SAT_W = 23;
    localparam int OFF_LIMIT = 8388607;
    localparam int DIVD_W  = POS_SHIFT + TRIG_FRAC + 1;
    localparam int DEN_W   = TRIG_W;
    localparam int DCNT_W  = $clog2(DIVD_W);
    localparam int MUL_W   = OFF_SAT_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int D2_W    = PROD_W + 1;
    localparam int SQ_W    = 48;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int SCNT_W  = $clog2(ROOT_W);
    localparam int COORD_W = 24;
    localparam int DIST_W  = 23;
    localparam int CFG_DATA_W = 64;

    typedef struct packed {
        logic [POS_W-1:0]   player_x;
        logic [POS_W-1:0]   player_y;
        logic [ANGLE_W-1:0] ray_angle;
    } ray_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic [DIST_W-1:0]         distance;
        logic                      side;
        logic                      hit;
    } res_t;

    typedef struct packed {
        logic [MAP_CELLS-1:0] wall_map;
        logic [STEP_W-1:0]    max_line_steps;
    } cfg_t;

    typedef struct packed {
        logic [DIVD_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    typedef enum logic [0:0] {
        CFG_WALL_MAP  = 1'b0,
        CFG_MAX_STEPS = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        DIR_H = 1'b0,
        DIR_V = 1'b1
    } dir_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_PREP,
        S_CHECK,
        S_MUL,
        S_DIV_A,
        S_WAIT_A,
        S_DIV_B,
        S_WAIT_B,
        S_STEP,
        S_SQUARE,
        S_ROOT,
        S_WAIT_ROOT
    } grc_state_t;

    // Arctangent per CORDIC iteration, in 1/65536 turn
    function automatic logic [CZ_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [CZ_W-1:0] v;
        unique case (i)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Clamp a CORDIC output into [0, 1.0]
    function automatic logic [TRIG_W-1:0] clamp_trig(input logic signed [CX_W-1:0] v);
        logic [TRIG_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > CX_W'(TRIG_ONE))
            r = TRIG_W'(TRIG_ONE);
        else
            r = v[TRIG_W-1:0];
        return r;
    endfunction

    // Saturate a point coordinate to the signed 24-bit output range
    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [PT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > PT_W'(OFF_LIMIT))
            r = COORD_W'(OFF_LIMIT);
        else if (v < -PT_W'(OFF_LIMIT + 1))
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/grc_cfg.sv
// ----------------------------------------------------------------------------
// grc_cfg
// Configuration register file: wall bitmap and line step limit.
// ----------------------------------------------------------------------------
module grc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output grc_pkg::cfg_t                   cfg
);
    import grc_pkg::*;

    logic [MAP_CELLS-1:0] wall_map_reg;
    logic [STEP_W-1:0]    max_steps_reg;

    // Always take a write
    assign cfg_ready = 1'b1;

    // Decode the register index and store the write data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_map_reg  <= '0;
            max_steps_reg <= STEP_W'(8);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_WALL_MAP:  wall_map_reg  <= cfg_data[MAP_CELLS-1:0];
                CFG_MAX_STEPS: max_steps_reg <= cfg_data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg.wall_map       = wall_map_reg;
    assign cfg.max_line_steps = max_steps_reg;

endmodule

// File: rtl/grc_div.sv
// ----------------------------------------------------------------------------
// grc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  grc_pkg::div_req_t           req,
    output logic                        done,
    output logic [grc_pkg::DIVD_W-1:0]  quo,
    output logic [grc_pkg::DEN_W-1:0]   rem
);
    import grc_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0]  quo_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W:0]     trial;
    logic               qbit;
    logic [DEN_W-1:0]   rem_next;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    // Control: iteration count and completion strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts in from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/grc_isqrt.sv
// ----------------------------------------------------------------------------
// grc_isqrt
// Integer square root, one result bit per cycle (floor).
// ----------------------------------------------------------------------------
module grc_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [grc_pkg::SQ_W-1:0]    value,
    output logic                        done,
    output logic [grc_pkg::ROOT_W-1:0]  root
);
    import grc_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [SCNT_W-1:0]  cnt_reg;
    logic [SQ_W-1:0]    v_reg;
    logic [SQ_W-1:0]    r_reg;
    logic [SQ_W-1:0]    bit_reg;
    logic [SQ_W-1:0]    trial;
    logic               ge;

    always_comb
    begin
        trial = r_reg + bit_reg;
        ge    = (v_reg >= trial);
    end

    // Control: iteration count and completion strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SCNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: bit walks down two places per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= {2'b01, {(SQ_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

// File: rtl/grid_ray_caster_unit.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_unit
// Casts one ray through a square-cell wall grid and reports the nearest hit.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive ray (player position, angle) and pulse start while busy is
//   low; the transaction is taken at that edge and busy rises.
//   Output: one result per ray, shown on result for one cycle with done high.
//   The receiver cannot stall; it must take the result in that cycle.
//   Config: write wall_map (index 0) or max_line_steps (index 1) through
//   cfg_valid/cfg_index/cfg_data while no ray is in flight; cfg_ready is high.
// Sequence: a ray runs through CORDIC and setup, then, for each direction
//   that is scanned, two divides and one step per grid line visited (at most
//   max_line_steps + 1), then squaring and the square root, and ends with
//   done. The one-bit-per-cycle divider runs twice per direction and the
//   square root unit once per ray. One ray at a time.
// Reset: clears the sequencer and strobes; wall_map resets to 0 and
//   max_line_steps to 8.
// ----------------------------------------------------------------------------
module grid_ray_caster_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  grc_pkg::ray_t                   ray,
    output logic                            done,
    output grc_pkg::res_t                   result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import grc_pkg::*;

    localparam logic [LINE_W-1:0] CELL_LINE = LINE_W'(1 << POS_SHIFT);
    localparam logic [D_W-1:0]    CELL_D    = D_W'(1 << POS_SHIFT);

    grc_state_t state_reg, state_next;
    cfg_t       cfg;

    // Input and trig registers
    logic [POS_W-1:0]         px_reg, py_reg;
    logic [TURN_W-1:0]        tt_reg;
    logic signed [CX_W-1:0]   cx_reg, cy_reg;
    logic signed [CZ_W-1:0]   cz_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [TRIG_W-1:0]        ca_reg, sa_reg;

    // Scan registers
    dir_t                     dir_reg;
    logic [POS_W-1:0]         pn_reg;
    logic                     fwd_reg, neg_reg;
    logic [TRIG_W-1:0]        num_reg, den_reg;
    logic signed [LINE_W-1:0] line_reg;
    logic [D_W-1:0]           d_reg;
    logic [STEP_W-1:0]        k_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [OFF_W-1:0]         off_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [DIVD_W-1:0]        qc_reg;
    logic [DEN_W-1:0]         rc_reg;

    // Per-direction outcome
    logic                     h_hit_reg, v_hit_reg;
    logic signed [PT_W-1:0]   h_m_reg, h_n_reg, v_m_reg, v_n_reg;
    logic [OFF_SAT_W-1:0]     h_off_reg, v_off_reg;
    logic [D_W-1:0]           h_d_reg, v_d_reg;
    logic [D2_W-1:0]          d2h_reg, d2v_reg;
    logic [1:0]               sq_reg;

    // Output registers
    logic                     done_reg;
    res_t                     result_reg;

    // Shared units
    logic                     div_start, div_done;
    div_req_t                 div_req;
    logic [DIVD_W-1:0]        div_quo;
    logic [DEN_W-1:0]         div_rem;
    logic                     sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        mul_p;

    // Combinational helpers
    logic signed [CX_W-1:0]   xs, ys;
    logic [CZ_W-1:0]          atan_c;
    logic [TRIG_W-1:0]        cm_c, sm_c;
    logic [1:0]               quad;
    logic [POS_W-1:0]         pm_c, pn_c;
    logic                     fwd_c, neg_c, skip_c;
    logic [TRIG_W-1:0]        num_c, den_c;
    logic signed [LINE_W-1:0] line0_c;
    logic [D_W-1:0]           d0_c;
    logic [OFF_SAT_W-1:0]     off_sat;
    logic signed [PT_W-1:0]   ln_c, line_pt;
    logic signed [LINE_W-POS_SHIFT-1:0] line_hi;
    logic signed [PT_W-POS_SHIFT-1:0] im_c, in_c, col_c, row_c;
    logic                     cell_ok, wall_c, limit_c, stop_c;
    logic [IDX_W-1:0]         idx_c;
    logic [DEN_W:0]           rsum_c;
    logic                     carry_c;
    logic                     pick_h;

    grc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    grc_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (SQ_W'(pick_h ? d2h_reg : d2v_reg)),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // CORDIC rotation step
    always_comb
    begin
        xs     = cx_reg >>> iter_reg;
        ys     = cy_reg >>> iter_reg;
        atan_c = atan_turn(iter_reg);
        cm_c   = clamp_trig(cx_reg);
        sm_c   = clamp_trig(cy_reg);
        quad   = tt_reg[TURN_W-1:TURN_W-2];
    end

    // Direction setup for the scan about to start
    always_comb
    begin
        if (dir_reg == DIR_H)
        begin
            pm_c   = py_reg;
            pn_c   = px_reg;
            fwd_c  = (tt_reg < 16'd32768);
            num_c  = ca_reg;
            den_c  = sa_reg;
            neg_c  = (quad == 2'd1) || (quad == 2'd2);
            skip_c = (tt_reg == 16'd0) || (tt_reg == 16'd32768) || (sa_reg == '0);
        end
        else
        begin
            pm_c   = px_reg;
            pn_c   = py_reg;
            fwd_c  = (tt_reg < 16'd16384) || (tt_reg > 16'd49152);
            num_c  = sa_reg;
            den_c  = ca_reg;
            neg_c  = (quad == 2'd2) || (quad == 2'd3);
            skip_c = (tt_reg == 16'd16384) || (tt_reg == 16'd49152) || (ca_reg == '0);
        end
        line0_c = LINE_W'({pm_c[POS_W-1:POS_SHIFT], {POS_SHIFT{1'b0}}});
        if (fwd_c)
        begin
            line0_c = line0_c + CELL_LINE;
            d0_c    = CELL_D - D_W'(pm_c[POS_SHIFT-1:0]);
        end
        else
        begin
            d0_c    = D_W'(pm_c[POS_SHIFT-1:0]);
        end
    end

    // Crossing point and wall test for the current line
    always_comb
    begin
        off_sat = (off_reg > OFF_W'(OFF_LIMIT)) ? OFF_SAT_W'(OFF_LIMIT)
                                                : off_reg[OFF_SAT_W-1:0];
        ln_c    = neg_reg ? (PT_W'(pn_reg) - PT_W'(off_sat))
                          : (PT_W'(pn_reg) + PT_W'(off_sat));
        line_pt = {{(PT_W-LINE_W){line_reg[LINE_W-1]}}, line_reg};
        line_hi = line_reg[LINE_W-1:POS_SHIFT];
        im_c    = {{(PT_W-LINE_W){line_hi[LINE_W-POS_SHIFT-1]}}, line_hi}
                  - (fwd_reg ? '0 : {{(PT_W-POS_SHIFT-1){1'b0}}, 1'b1});
        in_c    = ln_c[PT_W-1:POS_SHIFT];
        col_c   = (dir_reg == DIR_V) ? im_c : in_c;
        row_c   = (dir_reg == DIR_V) ? in_c : im_c;
        cell_ok = !col_c[PT_W-POS_SHIFT-1] && !row_c[PT_W-POS_SHIFT-1]
                  && (col_c < (PT_W-POS_SHIFT)'(MAP_WIDTH))
                  && (row_c < (PT_W-POS_SHIFT)'(MAP_HEIGHT));
        idx_c   = IDX_W'(row_c[ROW_W-1:0]) * IDX_W'(MAP_WIDTH) + IDX_W'(col_c[COL_W-1:0]);
        wall_c  = cell_ok && cfg.wall_map[idx_c];
        limit_c = (k_reg >= cfg.max_line_steps);
        stop_c  = limit_c || wall_c;
        rsum_c  = {1'b0, rem_reg} + {1'b0, rc_reg};
        carry_c = (rsum_c >= {1'b0, den_reg});
        pick_h  = h_hit_reg && (!v_hit_reg || (d2h_reg <= d2v_reg));
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = MUL_W'(d_reg);
        mul_b = MUL_W'(num_reg);
        if (state_reg == S_SQUARE)
        begin
            case (sq_reg)
                2'd0:    begin mul_a = h_off_reg;       mul_b = h_off_reg;       end
                2'd1:    begin mul_a = MUL_W'(h_d_reg); mul_b = MUL_W'(h_d_reg); end
                2'd2:    begin mul_a = v_off_reg;       mul_b = v_off_reg;       end
                default: begin mul_a = MUL_W'(v_d_reg); mul_b = MUL_W'(v_d_reg); end
            endcase
        end
        mul_p = mul_a * mul_b;
    end

    // Divider request: first crossing, then the per-line increment
    always_comb
    begin
        div_req.den = den_reg;
        if (state_reg == S_DIV_B)
            div_req.num = {num_reg, {POS_SHIFT{1'b0}}};
        else
            div_req.num = DIVD_W'(prod_reg) + DIVD_W'(den_reg >> 1);
    end

    // Sequencer: next state and unit strobes
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            S_IDLE:      if (start) state_next = S_CORDIC;
            S_CORDIC:    if (iter_reg == ITER_W'(CORDIC_ITERS - 1)) state_next = S_PREP;
            S_PREP:      state_next = S_CHECK;
            S_CHECK:
            begin
                if (!skip_c)
                    state_next = S_MUL;
                else if (dir_reg == DIR_V)
                    state_next = S_SQUARE;
            end
            S_MUL:       state_next = S_DIV_A;
            S_DIV_A:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT_A;
            end
            S_WAIT_A:    if (div_done) state_next = S_DIV_B;
            S_DIV_B:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT_B;
            end
            S_WAIT_B:    if (div_done) state_next = S_STEP;
            S_STEP:
            begin
                if (stop_c)
                    state_next = (dir_reg == DIR_H) ? S_CHECK : S_SQUARE;
            end
            S_SQUARE:    if (sq_reg == 2'd3) state_next = S_ROOT;
            S_ROOT:
            begin
                sqrt_start = 1'b1;
                state_next = S_WAIT_ROOT;
            end
            S_WAIT_ROOT: if (sqrt_done) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Hold the sequencer state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_WAIT_ROOT) && sqrt_done;
        end
    end

    // Datapath registers, advanced per sequencer state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                px_reg   <= ray.player_x;
                py_reg   <= ray.player_y;
                tt_reg   <= {ray.ray_angle, {(TURN_W-ANGLE_W){1'b0}}};
                cx_reg   <= CX_W'(CORDIC_X0);
                cy_reg   <= '0;
                cz_reg   <= {2'b00, ray.ray_angle[ANGLE_W-3:0], {(TURN_W-ANGLE_W){1'b0}}};
                iter_reg <= '0;
            end
            S_CORDIC:
            begin
                if (!cz_reg[CZ_W-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - $signed(atan_c);
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + $signed(atan_c);
                end
                iter_reg <= iter_reg + 1'b1;
            end
            S_PREP:
            begin
                ca_reg    <= quad[0] ? sm_c : cm_c;
                sa_reg    <= quad[0] ? cm_c : sm_c;
                dir_reg   <= DIR_H;
                h_hit_reg <= 1'b0;
                v_hit_reg <= 1'b0;
                v_m_reg   <= PT_W'(px_reg);
                v_n_reg   <= PT_W'(py_reg);
                sq_reg    <= '0;
            end
            S_CHECK:
            begin
                if (skip_c)
                begin
                    dir_reg <= DIR_V;
                end
                else
                begin
                    pn_reg   <= pn_c;
                    fwd_reg  <= fwd_c;
                    neg_reg  <= neg_c;
                    num_reg  <= num_c;
                    den_reg  <= den_c;
                    line_reg <= line0_c;
                    d_reg    <= d0_c;
                    k_reg    <= '0;
                end
            end
            S_MUL:       prod_reg <= mul_p;
            S_WAIT_A:
            begin
                if (div_done)
                begin
                    off_reg <= OFF_W'(div_quo);
                    rem_reg <= div_rem;
                end
            end
            S_WAIT_B:
            begin
                if (div_done)
                begin
                    qc_reg <= div_quo;
                    rc_reg <= div_rem;
                end
            end
            S_STEP:
            begin
                // Record this crossing; the last one recorded stands
                if (dir_reg == DIR_H)
                begin
                    h_m_reg   <= line_pt;
                    h_n_reg   <= ln_c;
                    h_off_reg <= off_sat;
                    h_d_reg   <= d_reg;
                    h_hit_reg <= wall_c && !limit_c;
                end
                else
                begin
                    v_m_reg   <= line_pt;
                    v_n_reg   <= ln_c;
                    v_off_reg <= off_sat;
                    v_d_reg   <= d_reg;
                    v_hit_reg <= wall_c && !limit_c;
                end
                if (stop_c)
                begin
                    dir_reg <= DIR_V;
                end
                else
                begin
                    // Advance one line: exact quotient/remainder update
                    line_reg <= fwd_reg ? (line_reg + CELL_LINE) : (line_reg - CELL_LINE);
                    d_reg    <= d_reg + CELL_D;
                    k_reg    <= k_reg + 1'b1;
                    off_reg  <= off_reg + OFF_W'(qc_reg) + OFF_W'(carry_c);
                    rem_reg  <= carry_c ? DEN_W'(rsum_c - {1'b0, den_reg})
                                        : rsum_c[DEN_W-1:0];
                end
            end
            S_SQUARE:
            begin
                case (sq_reg)
                    2'd0:    d2h_reg <= D2_W'(mul_p);
                    2'd1:    d2h_reg <= d2h_reg + D2_W'(mul_p);
                    2'd2:    d2v_reg <= D2_W'(mul_p);
                    default: d2v_reg <= d2v_reg + D2_W'(mul_p);
                endcase
                sq_reg <= sq_reg + 1'b1;
            end
            S_WAIT_ROOT:
            begin
                if (sqrt_done)
                begin
                    if (pick_h)
                    begin
                        result_reg.hit_x <= sat24(h_n_reg);
                        result_reg.hit_y <= sat24(h_m_reg);
                        result_reg.side  <= 1'b0;
                    end
                    else
                    begin
                        result_reg.hit_x <= sat24(v_m_reg);
                        result_reg.hit_y <= sat24(v_n_reg);
                        result_reg.side  <= v_hit_reg;
                    end
                    result_reg.hit <= h_hit_reg || v_hit_reg;
                    if ((h_hit_reg || v_hit_reg) && (sqrt_root <= ROOT_W'(OFF_LIMIT)))
                        result_reg.distance <= sqrt_root[DIST_W-1:0];
                    else
                        result_reg.distance <= DIST_W'(OFF_LIMIT);
                end
            end
            default: ;
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/grc_checker.sv
// ----------------------------------------------------------------------------
// grc_checker
// Port-level checks of the grid ray caster, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_ray_caster_unit_assert.svh"

module grc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input grc_pkg::res_t result
);
    import grc_pkg::*;

    `GRC_ASSERT_NEXT(a_take_sets_busy, start && !busy, busy, "accepted ray did not raise busy")
    `GRC_ASSERT_SAME(a_done_when_free, done, !busy, "result strobe while still busy")
    `GRC_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `GRC_ASSERT_SAME(a_miss_distance, done && !result.hit,
        (result.distance == DIST_W'(OFF_LIMIT)) && !result.side, "miss result not at maximum")

endmodule

bind grid_ray_caster_unit grc_checker u_grc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: sim/grid_ray_caster_unit_tb.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_unit_tb
// Self-checking bench for the grid ray caster. A driver takes rays from a
// pending queue, a built-in predictor casts each accepted ray in software and
// a monitor compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_ray_caster_unit_tb;
    import grc_pkg::*;

    localparam int  CLK_HALF   = 6;
    localparam int  RUN_LIMIT  = 2000000;
    localparam int  DRAIN_WAIT = 300;
    localparam int  N_RANDOM   = 1500;
    localparam longint CELL    = 64'sd1 << POS_SHIFT;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    ray_t          ray = '0;
    logic          done;
    res_t          result;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [0:0]    cfg_index = CFG_WALL_MAP;
    logic [63:0]   cfg_data = '0;

    // predictor copy of the registers
    logic [63:0]   walls = '0;
    logic [3:0]    line_limit = 4'd8;

    ray_t          ray_queue[$];
    res_t          pending_hits[$];
    int            send_idle = 0;
    int            mismatches = 0;
    int            cycles = 0;

    grid_ray_caster_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ray       (ray),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // CORDIC rotation of offset t, magnitudes clamped to [0, 1.0]
    function automatic void rotate(input longint t, output longint c, output longint s);
        longint x, y, z, xs, ys;
        int atan_tab[14];
        atan_tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        x = 9949;
        y = 0;
        z = t;
        for (int i = 0; i < 14; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
            else
            begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        c = (x < 0) ? 0 : (x > 16384) ? 16384 : x;
        s = (y < 0) ? 0 : (y > 16384) ? 16384 : y;
    endfunction

    function automatic bit is_wall(longint col, longint row);
        if (col < 0 || row < 0 || col >= MAP_WIDTH || row >= MAP_HEIGHT)
            return 1'b0;
        return walls[row * MAP_WIDTH + col];
    endfunction

    // step across grid lines of one axis; returns 1 on a wall hit
    function automatic bit walk_lines(longint pm, longint pn, bit fwd, longint num,
                                      longint den, bit neg, bit vert, output longint lm,
                                      output longint ln, output longint unsigned d2);
        longint line, d, off, im, inn;
        line = (pm >>> POS_SHIFT) <<< POS_SHIFT;
        if (fwd)
            line += CELL;
        for (int k = 0; ; k++)
        begin
            d = fwd ? line - pm : pm - line;
            off = (d * num + den / 2) / den;
            if (off > OFF_LIMIT)
                off = OFF_LIMIT;
            d2 = off * off + d * d;
            if (neg)
                off = -off;
            lm = line;
            ln = pn + off;
            if (k >= line_limit)
                return 1'b0;
            im = (line < 0) ? -1 : (line >>> POS_SHIFT) - (fwd ? 0 : 1);
            inn = (ln < 0) ? -1 : (ln >>> POS_SHIFT);
            if (vert ? is_wall(im, inn) : is_wall(inn, im))
                return 1'b1;
            line += fwd ? CELL : -CELL;
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] clip24(longint v);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    // expected result of one ray under the current registers
    function automatic res_t cast_ray(ray_t r);
        res_t o;
        longint px, py, tt, cm, sm, ca, sa, hx, hy, vx, vy, m, n;
        longint unsigned dh, dv, d2, root;
        int q;
        bit hh, vh;
        px = r.player_x;
        py = r.player_y;
        tt = (longint'(r.ray_angle) * 65536) / 4096;
        q = int'(tt >> 14);
        rotate(tt & 16383, cm, sm);
        ca = (q == 0 || q == 2) ? cm : sm;
        sa = (q == 0 || q == 2) ? sm : cm;
        hh = 0; vh = 0;
        hx = px; hy = py; vx = px; vy = py;
        dh = 0; dv = 0; d2 = 0;
        if (!(tt == 0 || tt == 32768 || sa == 0))
        begin
            hh = walk_lines(py, px, tt < 32768, ca, sa, q == 1 || q == 2, 1'b0, m, n, dh);
            hy = m; hx = n;
        end
        if (!(tt == 16384 || tt == 49152 || ca == 0))
        begin
            vh = walk_lines(px, py, tt < 16384 || tt > 49152, sa, ca, q == 2 || q == 3,
                            1'b1, m, n, dv);
            vx = m; vy = n;
        end
        o.side = 1'b0;
        o.hit = 1'b0;
        o.hit_x = clip24(vx);
        o.hit_y = clip24(vy);
        if (hh && (!vh || dh <= dv))
        begin
            o.hit_x = clip24(hx);
            o.hit_y = clip24(hy);
            d2 = dh;
            o.hit = 1'b1;
        end
        else if (vh)
        begin
            d2 = dv;
            o.side = 1'b1;
            o.hit = 1'b1;
        end
        if (o.hit)
        begin
            root = int_sqrt(d2);
            o.distance = (root > 8388607) ? 23'd8388607 : root[22:0];
        end
        else
            o.distance = 23'd8388607;
        return o;
    endfunction

    // Driver: present queued rays, hold a ray until taken, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        bit taken;
        if (!rst_n)
        begin
            start <= 1'b0;
            ray <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                pending_hits.push_back(cast_ray(ray));
                void'(ray_queue.pop_front());
            end
            if (start && !taken)
                start <= 1'b1;
            else if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                start <= 1'b1;
                ray <= ray_queue[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each result against the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (result.hit_x !== want.hit_x || result.hit_y !== want.hit_y ||
                    result.distance !== want.distance || result.side !== want.side ||
                    result.hit !== want.hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WALL_MAP)
            walls = val;
        else
            line_limit = val[3:0];
    endtask

    // hold until every queued ray is taken and every result is back
    task automatic drain();
        while (ray_queue.size() != 0 || pending_hits.size() != 0 || start || busy)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic ray_t rand_ray();
        ray_t r;
        r.player_x = POS_W'($urandom);
        r.player_y = POS_W'($urandom);
        r.ray_angle = ANGLE_W'($urandom);
        // snap onto grid lines or cardinal directions now and then
        if ($urandom_range(9) == 0)
            r.player_x[POS_SHIFT-1:0] = '0;
        if ($urandom_range(9) == 0)
            r.player_y[POS_SHIFT-1:0] = '0;
        if ($urandom_range(4) == 0)
            r.ray_angle = 12'($urandom_range(3) * 1024 + $urandom_range(2) - 1);
        return r;
    endfunction

    function automatic ray_t mk_ray(int x, int y, int a);
        ray_t r;
        r.player_x = POS_W'(x);
        r.player_y = POS_W'(y);
        r.ray_angle = ANGLE_W'(a);
        return r;
    endfunction

    initial
    begin
        logic [63:0] map_val;
        int          lim;
        int          angles[10];
        angles = '{0, 1, 512, 1024, 1536, 2048, 2560, 3072, 3584, 4095};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bordered room with cell 0 walled, rays from the middle and elsewhere
        write_reg(CFG_WALL_MAP, 64'hFF81_8181_8181_81FF);
        write_reg(CFG_MAX_STEPS, 64'd8);
        foreach (angles[i])
            ray_queue.push_back(mk_ray(70000, 60000, angles[i]));
        ray_queue.push_back(mk_ray(0, 0, 2560));
        ray_queue.push_back(mk_ray(131071, 131071, 512));
        ray_queue.push_back(mk_ray(3 * 16384, 4 * 16384, 0));
        ray_queue.push_back(mk_ray(3 * 16384, 4 * 16384, 1024));
        ray_queue.push_back(mk_ray(20000, 20000, 2560));
        drain();

        // Directed: empty map, no hits at all
        write_reg(CFG_WALL_MAP, 64'd0);
        write_reg(CFG_MAX_STEPS, 64'd15);
        ray_queue.push_back(mk_ray(70000, 60000, 300));
        ray_queue.push_back(mk_ray(70000, 60000, 1024));
        ray_queue.push_back(mk_ray(131071, 0, 3000));
        drain();

        // Directed: zero, then one, step limit and a solid map
        write_reg(CFG_MAX_STEPS, 64'd0);
        write_reg(CFG_WALL_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
        ray_queue.push_back(mk_ray(70000, 60000, 700));
        ray_queue.push_back(mk_ray(70000, 60000, 2048));
        drain();
        write_reg(CFG_MAX_STEPS, 64'd1);
        ray_queue.push_back(mk_ray(5000, 126000, 3500));
        drain();

        // Random phases: sender idles 9%, then 56%, then never
        for (int ph = 0; ph < 9; ph++)
        begin
            send_idle = (ph < 3) ? 9 : (ph < 6) ? 56 : 0;
            case (ph % 3)
                0: map_val = {$urandom, $urandom} & {$urandom, $urandom};
                1: map_val = {$urandom, $urandom};
                default: map_val = {$urandom, $urandom} | {$urandom, $urandom};
            endcase
            if (ph == 4)
                map_val = 64'hFFFF_FFFF_FFFF_FFFF;
            lim = (ph == 2) ? 15 : (ph == 5) ? 1 : (ph == 7) ? 0 : $urandom_range(15);
            write_reg(CFG_WALL_MAP, map_val);
            write_reg(CFG_MAX_STEPS, 64'(lim));
            repeat (N_RANDOM / 9) ray_queue.push_back(rand_ray());
            drain();
        end

        if (mismatches == 0 && pending_hits.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
